FILE: rtl/bitmap_first_fit_frame_allocator_macros.svh
// assertion macros shared by the allocator modules
// no dependencies
`ifndef BITMAP_FIRST_FIT_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_FRAME_ALLOCATOR_MACROS_SVH
// implication checked every clock outside reset
`define BFA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define BFA_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: rtl/bffa_pkg.sv
// package for the frame allocator: request and status codes, controller states
// no dependencies
package bffa_pkg;
  localparam int NUM_FRAMES_DEF    = 256;
  localparam int NUM_PROCESSES_DEF = 16;

  typedef enum logic [1:0] {
    REQ_ALLOC     = 2'd0,
    REQ_FREE_PROC = 2'd1,
    REQ_FREE_ONE  = 2'd2,
    REQ_NONE      = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_LEN  = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_UNUSED    = 3'd3,
    ST_NOT_OWNED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_MARK, S_FPROC, S_FONE_RD, S_FONE, S_STATS, S_DIV_LOAD, S_DIV,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic find_start;
    logic find_step;
    logic mark_step;
    logic fproc_step;
    logic fone_rd;
    logic fone_do;
    logic stats_start;
    logic stats_step;
    logic div_start;
    logic div_step;
    logic scan_clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic    scan_last;
    logic    found;
    logic    mark_last;
    logic    div_last;
    logic    fone_used;
    logic    early_err;
    status_t early_status;
    req_t    kind;
  } sts_t;
endpackage

FILE: rtl/bffa_if.sv
// valid/ready channel interfaces for request and result beats
// depends on nothing
interface bffa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] process_id;
  logic [8:0] block_count;
  logic [7:0] frame_index;
  modport source (output valid, req_type, process_id, block_count, frame_index,
                  input ready);
  modport sink   (input valid, req_type, process_id, block_count, frame_index,
                  output ready);
endinterface

interface bffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  start_frame;
  logic [8:0]  used_frames;
  logic [8:0]  free_frames;
  logic [8:0]  largest_free_run;
  logic [7:0]  free_run_count;
  logic [7:0]  external_waste;
  logic [15:0] fragmentation_q16;
  logic [31:0] total_allocations;
  logic [31:0] total_releases;
  logic [8:0]  process_frames;
  logic [7:0]  process_start;
  modport source (output valid, status, start_frame, used_frames, free_frames,
                  largest_free_run, free_run_count, external_waste,
                  fragmentation_q16, total_allocations, total_releases,
                  process_frames, process_start, input ready);
  modport sink   (input valid, status, start_frame, used_frames, free_frames,
                  largest_free_run, free_run_count, external_waste,
                  fragmentation_q16, total_allocations, total_releases,
                  process_frames, process_start, output ready);
endinterface

FILE: rtl/bitmap_first_fit_frame_allocator.sv
// top level of the bitmap first-fit frame allocator
// depends on bffa_pkg, bffa_if, bffa_ctrl, bffa_dp
//
// channel | dir | beat
// req     | in  | req_type, process_id, block_count, frame_index
// rsp     | out | status, counts, fragmentation, process figures
//
// one request at a time; frame scans visit one frame a cycle. allocate: find scan
// to the first fitting run, then mark pass over it; a failed fit scans to the last
// frame. free-process: release scan of all frames. free-frame: one frame read.
// rejected or unknown requests do none of these. all then run a statistics scan over
// all frames, a divide load, a serial divide and the output state.
// reset clears the used map and counters at once; a stalled result blocks input.
module bitmap_first_fit_frame_allocator #(
  parameter int NUM_FRAMES    = bffa_pkg::NUM_FRAMES_DEF,
  parameter int NUM_PROCESSES = bffa_pkg::NUM_PROCESSES_DEF
) (
  input logic      clk,
  input logic      rst,
  bffa_req_if.sink   req,
  bffa_rsp_if.source rsp
);
  import bffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller sequences the scans, datapath holds the maps, tables and counters
  bffa_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (req.valid), .in_ready (req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd, .sts
  );

  bffa_dp #(.NUM_FRAMES(NUM_FRAMES), .NUM_PROCESSES(NUM_PROCESSES)) u_dp (
    .clk, .rst,
    .req_type(req.req_type), .process_id(req.process_id),
    .block_count(req.block_count), .frame_index(req.frame_index),
    .cmd, .sts,
    .status(rsp.status), .start_frame(rsp.start_frame),
    .used_frames(rsp.used_frames), .free_frames(rsp.free_frames),
    .largest_free_run(rsp.largest_free_run), .free_run_count(rsp.free_run_count),
    .external_waste(rsp.external_waste), .fragmentation_q16(rsp.fragmentation_q16),
    .total_allocations(rsp.total_allocations), .total_releases(rsp.total_releases),
    .process_frames(rsp.process_frames), .process_start(rsp.process_start)
  );
endmodule

FILE: rtl/bffa_ctrl.sv
// controller state machine for the frame allocator
// depends on bffa_pkg and the macros header
`include "bitmap_first_fit_frame_allocator_macros.svh"
module bffa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output bffa_pkg::cmd_t cmd,
  input  bffa_pkg::sts_t sts
);
  import bffa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        // dispatch happens next cycle once the request is latched
        state_next = S_FIND;
      end
      S_FIND: begin
        if (sts.early_err || sts.kind == REQ_NONE) begin
          cmd.stats_start = 1'b1;
          state_next = S_STATS;
        end else if (sts.kind == REQ_ALLOC) begin
          cmd.find_step = 1'b1;
          if (sts.found) begin
            cmd.scan_clear = 1'b1;
            state_next = S_MARK;
          end else if (sts.scan_last) begin
            cmd.stats_start = 1'b1;
            state_next = S_STATS;
          end
        end else if (sts.kind == REQ_FREE_PROC) begin
          cmd.fproc_step = 1'b1;
          if (sts.scan_last) begin
            cmd.stats_start = 1'b1;
            state_next = S_STATS;
          end
        end else begin
          cmd.fone_rd = 1'b1;
          state_next = S_FONE;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          cmd.stats_start = 1'b1;
          state_next = S_STATS;
        end
      end
      S_FONE: begin
        cmd.fone_do = 1'b1;
        cmd.stats_start = 1'b1;
        state_next = S_STATS;
      end
      S_STATS: begin
        cmd.stats_step = 1'b1;
        if (sts.scan_last) state_next = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        // statistics of the last frame are registered by now
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  `BFA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `BFA_ASSERT_IMP(a_no_overlap, clk, rst, in_ready, !out_valid)
  `BFA_ASSERT_NXT(a_load_leaves_idle, clk, rst, cmd.load, !in_ready)
endmodule

FILE: rtl/bffa_dp.sv
// datapath: frame map, owner memory, process tables, counters, statistics, divider
// depends on bffa_pkg and the macros header
`include "bitmap_first_fit_frame_allocator_macros.svh"
module bffa_dp #(
  parameter int NUM_FRAMES    = bffa_pkg::NUM_FRAMES_DEF,
  parameter int NUM_PROCESSES = bffa_pkg::NUM_PROCESSES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     req_type,
  input  logic [3:0]     process_id,
  input  logic [8:0]     block_count,
  input  logic [7:0]     frame_index,
  input  bffa_pkg::cmd_t cmd,
  output bffa_pkg::sts_t sts,
  output logic [2:0]     status,
  output logic [7:0]     start_frame,
  output logic [8:0]     used_frames,
  output logic [8:0]     free_frames,
  output logic [8:0]     largest_free_run,
  output logic [7:0]     free_run_count,
  output logic [7:0]     external_waste,
  output logic [15:0]    fragmentation_q16,
  output logic [31:0]    total_allocations,
  output logic [31:0]    total_releases,
  output logic [8:0]     process_frames,
  output logic [7:0]     process_start
);
  import bffa_pkg::*;

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int CW = FW + 1;
  localparam int PW = $clog2(NUM_PROCESSES);

  // used bits in flip-flops, reset at once; owner kept beside them
  logic [NUM_FRAMES-1:0] used;
  logic [PW-1:0]         owner [NUM_FRAMES];
  logic [CW-1:0]         pcount [NUM_PROCESSES];
  logic [FW-1:0]         pstart [NUM_PROCESSES];
  logic [CW-1:0]         used_cnt;
  logic [31:0]           alloc_cnt, rel_cnt;

  // latched request
  req_t        kind;
  logic [3:0]  pid;
  logic [8:0]  need;
  logic [7:0]  fidx;
  logic        pid_ok, fidx_ok;
  status_t     st;
  logic [FW-1:0] start_q;

  // scan state
  logic [FW-1:0] idx, idx_next;
  logic [PW-1:0] owner_q;
  logic [CW-1:0] run, begin_q, nfree, largest, cur, freed;
  logic [8:0]    runs;
  logic          in_run;
  logic [PW-1:0] fone_owner;
  logic          fone_used_q;

  // divider
  logic [CW-1:0] div_d;
  logic [CW:0]   rem;
  logic [15:0]   quo;
  logic [4:0]    div_cnt;

  logic [PW-1:0] pidx;
  logic          scan_last;
  logic [CW-1:0] run_inc;
  logic [CW-1:0] waste;
  logic [CW:0]   rem_sh;
  logic          own_hit;

  assign pidx      = pid[PW-1:0];
  assign scan_last = (idx == FW'(NUM_FRAMES - 1));
  assign run_inc   = run + 1'b1;
  assign waste     = nfree - largest;
  assign rem_sh    = {rem[CW-1:0], 1'b0};
  // owner_q holds the owner of frame idx, registered from owner[idx_next] alongside idx
  assign own_hit   = used[idx] && owner_q == pidx;

  // scan pointer: restart, rewind to the found run, or step
  always_comb begin
    idx_next = idx;
    if (cmd.load || cmd.stats_start) idx_next = '0;
    else if (cmd.scan_clear) idx_next = (run == '0) ? idx : begin_q[FW-1:0];
    else if (cmd.find_step || cmd.mark_step || cmd.fproc_step || cmd.stats_step)
      idx_next = idx + 1'b1;
  end

  always_comb begin
    sts.scan_last    = scan_last;
    sts.found        = !used[idx] && (run_inc >= CW'(need));
    sts.mark_last    = (idx == FW'(CW'(begin_q) + CW'(need) - 1'b1));
    sts.div_last     = (div_cnt == 5'd15);
    sts.fone_used    = fone_used_q;
    sts.early_err    = 1'b0;
    sts.early_status = ST_OK;
    if (kind == REQ_ALLOC && need == 9'd0) begin
      sts.early_err = 1'b1; sts.early_status = ST_ZERO_LEN;
    end else if (kind == REQ_ALLOC && (!pid_ok || 10'(need) > 10'(NUM_FRAMES))) begin
      sts.early_err = 1'b1; sts.early_status = ST_NO_FIT;
    end else if (kind == REQ_FREE_PROC && !pid_ok) begin
      sts.early_err = 1'b1; sts.early_status = ST_NOT_OWNED;
    end else if (kind == REQ_FREE_ONE && !fidx_ok) begin
      sts.early_err = 1'b1; sts.early_status = ST_UNUSED;
    end
    sts.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      used_cnt <= '0;
      alloc_cnt <= '0;
      rel_cnt <= '0;
      for (int p = 0; p < NUM_PROCESSES; p++) begin
        pcount[p] <= '0;
        pstart[p] <= '0;
      end
    end else begin
      if (cmd.mark_step) begin
        used[idx]  <= 1'b1;
        owner[idx] <= pidx;
        if (sts.mark_last) begin
          used_cnt  <= used_cnt + CW'(need);
          alloc_cnt <= alloc_cnt + 1'b1;
          pcount[pidx] <= pcount[pidx] + CW'(need);
          if (pstart[pidx] == '0 && pcount[pidx] == '0) pstart[pidx] <= begin_q[FW-1:0];
        end
      end
      if (cmd.fproc_step) begin
        if (own_hit) used[idx] <= 1'b0;
        if (scan_last && (freed != '0 || own_hit)) begin
          used_cnt <= used_cnt - (freed + CW'(own_hit));
          rel_cnt  <= rel_cnt + 32'(freed + CW'(own_hit));
          pcount[pidx] <= '0;
          pstart[pidx] <= '0;
        end
      end
      if (cmd.fone_do && fone_used_q) begin
        used[fidx[FW-1:0]] <= 1'b0;
        used_cnt <= used_cnt - 1'b1;
        rel_cnt  <= rel_cnt + 1'b1;
        if (pcount[fone_owner] != '0) pcount[fone_owner] <= pcount[fone_owner] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    owner_q <= owner[idx_next];
    if (cmd.load) begin
      kind    <= req_t'(req_type);
      pid     <= process_id;
      need    <= block_count;
      fidx    <= frame_index;
      pid_ok  <= 32'(process_id) < NUM_PROCESSES;
      fidx_ok <= 32'(frame_index) < NUM_FRAMES;
      st      <= ST_OK;
      start_q <= '0;
      run     <= '0;
      freed   <= '0;
    end
    if (cmd.find_step) begin
      if (used[idx]) run <= '0;
      else begin
        run <= run_inc;
        if (run == '0) begin_q <= CW'(idx);
      end
      if (sts.found) start_q <= (run == '0) ? idx : begin_q[FW-1:0];
      else if (scan_last) st <= ST_NO_FIT;
    end
    if (cmd.fproc_step) begin
      if (own_hit) freed <= freed + 1'b1;
      if (scan_last && freed == '0 && !own_hit) st <= ST_NOT_OWNED;
    end
    if (cmd.fone_rd) begin
      fone_used_q <= used[fidx[FW-1:0]];
      fone_owner  <= owner[fidx[FW-1:0]];
    end
    if (cmd.fone_do && !fone_used_q) st <= ST_UNUSED;
    if (cmd.stats_start) begin
      if (sts.early_err) st <= sts.early_status;
      nfree <= '0; largest <= '0; cur <= '0; runs <= '0; in_run <= 1'b0;
    end
    if (cmd.stats_step) begin
      if (!used[idx]) begin
        nfree <= nfree + 1'b1;
        cur <= cur + 1'b1;
        if (!in_run) runs <= runs + 1'b1;
        in_run <= 1'b1;
        if (cur + 1'b1 > largest) largest <= cur + 1'b1;
      end else begin
        cur <= '0; in_run <= 1'b0;
      end
    end
    if (cmd.div_start) begin
      div_d <= nfree; rem <= {1'b0, waste}; quo <= '0; div_cnt <= '0;
    end
    if (cmd.div_step) begin
      // restoring divide of waste<<16 by free count, one quotient bit per cycle
      if (rem_sh >= {1'b0, div_d}) begin
        rem <= rem_sh - {1'b0, div_d};
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[14:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // waste < nfree whenever a frame is free, so the remainder starts at waste
  // and sixteen zero bits shifted in give a quotient below 2^16
  assign status            = st;
  assign start_frame       = (st == ST_OK && kind == REQ_ALLOC) ? 8'(start_q) : 8'd0;
  assign used_frames       = 9'(used_cnt);
  assign free_frames       = 9'(nfree);
  assign largest_free_run  = 9'(largest);
  assign free_run_count    = 8'(runs);
  assign external_waste    = 8'(waste);
  assign fragmentation_q16 = (nfree == '0) ? 16'd0 : quo;
  assign total_allocations = alloc_cnt;
  assign total_releases    = rel_cnt;
  assign process_frames    = pid_ok ? 9'(pcount[pidx]) : 9'd0;
  assign process_start     = pid_ok ? 8'(pstart[pidx]) : 8'd0;

  `BFA_ASSERT_IMP(a_used_le, clk, rst, 1'b1, used_cnt <= CW'(NUM_FRAMES))
  `BFA_ASSERT_IMP(a_largest_le, clk, rst, cmd.div_step, largest <= nfree)
  `BFA_ASSERT_NXT(a_alloc_inc, clk, rst, cmd.mark_step && sts.mark_last,
                  alloc_cnt == $past(alloc_cnt) + 1)
endmodule

FILE: verif/bffa_tb_pkg.sv
`timescale 1ns / 1ps
// shared sizes for the allocator testbench
// depends on bffa_pkg
package bffa_tb_pkg;
  import bffa_pkg::*;
  localparam int FRAMES = NUM_FRAMES_DEF;
  localparam int PROCS  = NUM_PROCESSES_DEF;
endpackage

FILE: verif/bffa_checker.sv
`timescale 1ns / 1ps
// checker for the frame allocator: mirrors the frame map, predicts each result beat
// depends on bffa_pkg, bffa_if, bffa_tb_pkg
module bffa_checker (
  input  logic          clk,
  input  logic          rst,
  bffa_req_if.sink      req_mon,
  bffa_rsp_if.sink      rsp_mon,
  output int            errors,
  output int            pending
);
  import bffa_pkg::*;
  import bffa_tb_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  start_frame;
    logic [8:0]  used_frames;
    logic [8:0]  free_frames;
    logic [8:0]  largest_free_run;
    logic [7:0]  free_run_count;
    logic [7:0]  external_waste;
    logic [15:0] fragmentation_q16;
    logic [31:0] total_allocations;
    logic [31:0] total_releases;
    logic [8:0]  process_frames;
    logic [7:0]  process_start;
  } figures_t;

  bit         map_used [FRAMES];
  bit [3:0]   map_owner [FRAMES];
  int         owned_cnt [PROCS];
  int         owner_start [PROCS];
  int         in_use;
  bit [31:0]  alloc_total, release_total;
  figures_t   awaited [$];

  assign pending = awaited.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic figures_t predict_result(req_t kind, logic [3:0] pid,
                                              logic [8:0] need, logic [7:0] fidx);
    figures_t f;
    int run, first_free, freed, nfree, longest, cur, runs, waste;
    bit found, fresh;
    f = '0;
    f.status = ST_OK;
    if (kind == REQ_ALLOC) begin
      if (need == 0) begin
        f.status = ST_ZERO_LEN;
      end else begin
        run = 0; first_free = 0; found = 0;
        for (int i = 0; i < FRAMES; i++) begin
          if (!map_used[i]) begin
            if (run == 0) first_free = i;
            run++;
            if (run >= need) begin
              found = 1;
              break;
            end
          end else begin
            run = 0;
          end
        end
        if (!found) begin
          f.status = ST_NO_FIT;
        end else begin
          fresh = owned_cnt[pid] == 0;
          for (int i = first_free; i < first_free + need; i++) begin
            map_used[i] = 1;
            map_owner[i] = pid;
          end
          in_use += need;
          alloc_total++;
          owned_cnt[pid] += need;
          // start is only recorded for a process that held nothing
          if (owner_start[pid] == 0 && fresh) owner_start[pid] = first_free;
          f.start_frame = 8'(first_free);
        end
      end
    end else if (kind == REQ_FREE_PROC) begin
      freed = 0;
      for (int i = 0; i < FRAMES; i++)
        if (map_used[i] && map_owner[i] == pid) begin
          map_used[i] = 0;
          freed++;
        end
      if (freed == 0) begin
        f.status = ST_NOT_OWNED;
      end else begin
        in_use -= freed;
        release_total += freed;
        owned_cnt[pid] = 0;
        owner_start[pid] = 0;
      end
    end else if (kind == REQ_FREE_ONE) begin
      if (!map_used[fidx]) begin
        f.status = ST_UNUSED;
      end else begin
        map_used[fidx] = 0;
        in_use--;
        release_total++;
        if (owned_cnt[map_owner[fidx]] > 0) owned_cnt[map_owner[fidx]]--;
      end
    end
    nfree = 0; longest = 0; cur = 0; runs = 0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!map_used[i]) begin
        nfree++;
        cur++;
        if (cur == 1) runs++;
        if (cur > longest) longest = cur;
      end else begin
        cur = 0;
      end
    end
    waste = nfree - longest;
    f.used_frames       = 9'(in_use);
    f.free_frames       = 9'(nfree);
    f.largest_free_run  = 9'(longest);
    f.free_run_count    = 8'(runs);
    f.external_waste    = 8'(waste);
    f.fragmentation_q16 = nfree > 0 ? 16'((longint'(waste) << 16) / nfree) : 16'd0;
    f.total_allocations = alloc_total;
    f.total_releases    = release_total;
    f.process_frames    = 9'(owned_cnt[pid]);
    f.process_start     = 8'(owner_start[pid]);
    return f;
  endfunction

  always @(posedge clk) begin
    figures_t got, want;
    if (rst) begin
      errors = 0;
      foreach (map_used[i]) begin
        map_used[i] = 0;
        map_owner[i] = 0;
      end
      foreach (owned_cnt[i]) begin
        owned_cnt[i] = 0;
        owner_start[i] = 0;
      end
      in_use = 0; alloc_total = 0; release_total = 0;
      awaited.delete();
    end else begin
      if (req_mon.valid && req_mon.ready)
        awaited.push_back(predict_result(req_t'(req_mon.req_type), req_mon.process_id,
                                         req_mon.block_count, req_mon.frame_index));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = {rsp_mon.status, rsp_mon.start_frame, rsp_mon.used_frames,
               rsp_mon.free_frames, rsp_mon.largest_free_run, rsp_mon.free_run_count,
               rsp_mon.external_waste, rsp_mon.fragmentation_q16,
               rsp_mon.total_allocations, rsp_mon.total_releases,
               rsp_mon.process_frames, rsp_mon.process_start};
        if (awaited.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = awaited.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.start_frame != want.start_frame)
            report("start_frame", got.start_frame, want.start_frame);
          if (got.used_frames != want.used_frames)
            report("used_frames", got.used_frames, want.used_frames);
          if (got.free_frames != want.free_frames)
            report("free_frames", got.free_frames, want.free_frames);
          if (got.largest_free_run != want.largest_free_run)
            report("largest_free_run", got.largest_free_run, want.largest_free_run);
          if (got.free_run_count != want.free_run_count)
            report("free_run_count", got.free_run_count, want.free_run_count);
          if (got.external_waste != want.external_waste)
            report("external_waste", got.external_waste, want.external_waste);
          if (got.fragmentation_q16 != want.fragmentation_q16)
            report("fragmentation_q16", got.fragmentation_q16, want.fragmentation_q16);
          if (got.total_allocations != want.total_allocations)
            report("total_allocations", got.total_allocations, want.total_allocations);
          if (got.total_releases != want.total_releases)
            report("total_releases", got.total_releases, want.total_releases);
          if (got.process_frames != want.process_frames)
            report("process_frames", got.process_frames, want.process_frames);
          if (got.process_start != want.process_start)
            report("process_start", got.process_start, want.process_start);
        end
      end
    end
  end
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// testbench top for the frame allocator: stimulus, stalls, watchdog, verdict
// depends on bffa_pkg, bffa_if, bffa_tb_pkg, bffa_checker, the allocator rtl
module tb;
  import bffa_pkg::*;
  import bffa_tb_pkg::*;

  // a request and the long hold-off both finish well inside this limit,
  // so a correct run never sits near this many cycles without a beat
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_BEATS = 530;

  logic clk, rst;
  int   errors, pending;
  int   idle_cycles;
  bit   hold_off;     // long receiver stall requested by the stimulus
  bit   stim_done;

  bffa_req_if req ();
  bffa_rsp_if rsp ();

  bitmap_first_fit_frame_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  bffa_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .req_mon (req.sink),
    .rsp_mon (rsp.sink),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    req.valid = 0;
    req.req_type = '0;
    req.process_id = '0;
    req.block_count = '0;
    req.frame_index = '0;
    rsp.ready = 0;
    rst = 1;
    repeat (5) @(posedge clk);
    rst <= 0;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int phase;
    phase = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off)
        rsp.ready <= 0;
      else if ((phase / 200) % 3 == 0)
        rsp.ready <= 1;                        // stretch with no stalls
      else
        rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // one beat offered; held until accepted
  task automatic send_beat(input req_t kind, input logic [3:0] pid,
                           input logic [8:0] count, input logic [7:0] fidx);
    req.valid       <= 1;
    req.req_type    <= kind;
    req.process_id  <= pid;
    req.block_count <= count;
    req.frame_index <= fidx;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic idle_gap();
    req.valid <= 0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int burst, k, r;
    logic [8:0] cnt;
    stim_done = 0;
    hold_off = 0;
    @(negedge rst);
    @(posedge clk);
    // directed: error cases on an empty map, then fills, frees and refits
    send_beat(REQ_ALLOC, 4'd0, 9'd0, 8'd0);        // zero length
    send_beat(REQ_FREE_PROC, 4'd3, 9'd0, 8'd0);    // nothing owned
    send_beat(REQ_FREE_ONE, 4'd0, 9'd0, 8'd255);   // frame unused
    send_beat(REQ_NONE, 4'd15, 9'h1ff, 8'hff);     // unknown request
    send_beat(REQ_ALLOC, 4'd1, 9'd257, 8'd0);      // no fit, too long
    send_beat(REQ_ALLOC, 4'd2, 9'd256, 8'd0);      // whole map
    send_beat(REQ_ALLOC, 4'd3, 9'd1, 8'd0);        // no fit, map full
    send_beat(REQ_FREE_ONE, 4'd0, 9'd0, 8'd255);   // last frame
    send_beat(REQ_FREE_ONE, 4'd0, 9'd0, 8'd0);     // first frame
    send_beat(REQ_FREE_ONE, 4'd0, 9'd0, 8'd100);   // hole in the middle
    send_beat(REQ_ALLOC, 4'd15, 9'd1, 8'd0);       // first fit takes frame 0
    send_beat(REQ_FREE_PROC, 4'd2, 9'd0, 8'd0);
    // start record: process 4 at frame 0 keeps start 0, a later alloc does not overwrite it
    send_beat(REQ_FREE_PROC, 4'd15, 9'd0, 8'd0);
    send_beat(REQ_ALLOC, 4'd4, 9'd3, 8'd0);
    send_beat(REQ_ALLOC, 4'd4, 9'd2, 8'd0);
    send_beat(REQ_ALLOC, 4'd5, 9'd4, 8'd0);
    send_beat(REQ_FREE_ONE, 4'd0, 9'd0, 8'd5);     // owner count decrement
    send_beat(REQ_FREE_PROC, 4'd4, 9'd0, 8'd0);
    send_beat(REQ_FREE_PROC, 4'd5, 9'd0, 8'd0);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (k = 0; k < 6; k++)
          send_beat(REQ_ALLOC, k[3:0], 9'(1 + k), 8'd0);
      end
    join
    drain();

    // random: mostly allocs and frees of random frames, small sizes
    for (k = 0; k < RANDOM_BEATS; k += burst) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst; b++) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) cnt = 9'($urandom_range(0, 511));
        else if ($urandom_range(0, 9) == 0) cnt = 9'($urandom_range(0, 256));
        else cnt = 9'($urandom_range(1, 12));
        if (r < 45)
          send_beat(REQ_ALLOC, 4'($urandom_range(0, 15)), cnt,
                    8'($urandom_range(0, 255)));
        else if (r < 60)
          send_beat(REQ_FREE_PROC, 4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)),
                    8'($urandom_range(0, 255)));
        else if (r < 96)
          send_beat(REQ_FREE_ONE, 4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)),
                    8'($urandom_range(0, 255)));
        else
          send_beat(REQ_NONE, 4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)),
                    8'($urandom_range(0, 255)));
      end
      // sender waits out every result once, halfway through
      if (k < RANDOM_BEATS / 2 && k + burst >= RANDOM_BEATS / 2) drain();
      else if ($urandom_range(0, 2) != 0) idle_gap();
    end
    drain();
    req.valid <= 0;
    stim_done = 1;
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    repeat (600) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
